/* rtl/sid_pkg.sv */
// Package for the signed integer divider: data width, derived bus widths,
// limit constants and the record carried down the division pipeline.
// No dependencies.
package sid_pkg;

	// Operand and quotient width.
	localparam int DATA_WIDTH = 32;

	// Stream bus widths, padded up to whole bytes.
	localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

	// Largest positive quotient, used when the most negative value is divided by -1.
	localparam logic [DATA_WIDTH-1:0] INT_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};

	// One entry of the division pipeline.
	typedef struct packed {
		logic                  valid;
		logic                  neg;   // Quotient takes a minus sign.
		logic                  zero;  // Divisor was zero.
		logic [DATA_WIDTH-1:0] dm;    // Divisor magnitude.
		logic [DATA_WIDTH-1:0] rem;   // Partial remainder.
		logic [DATA_WIDTH-1:0] nq;    // Dividend bits still to use, quotient bits shifted in.
	} div_stage_t;

endpackage

/* rtl/sid_div_step.sv */
// One registered step of restoring division: produces one quotient bit.
// Depends on sid_pkg for the data width and the pipeline record.
module sid_div_step
	import sid_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ce,
	input  div_stage_t stage_in,
	output div_stage_t stage_out
);

	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;
	logic                  qbit;
	div_stage_t            step_next;
	div_stage_t            stage_s2;
	logic                  valid_s2;

	// Shift in the next dividend bit and try to subtract the divisor.
	always_comb begin
		trial = {stage_in.rem, stage_in.nq[DATA_WIDTH-1]};
		diff  = trial - {1'b0, stage_in.dm};
		qbit  = ~diff[DATA_WIDTH];
		step_next       = stage_in;
		step_next.rem   = qbit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
		step_next.nq    = {stage_in.nq[DATA_WIDTH-2:0], qbit};
	end

	// Valid bit of this step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s2 <= stage_in.valid;
		end
	end

	// Payload of this step.
	always_ff @(posedge clk) begin
		if (ce) begin
			stage_s2 <= step_next;
		end
	end

	always_comb begin
		stage_out       = stage_s2;
		stage_out.valid = valid_s2;
	end

endmodule

/* rtl/signed_int_divider_core.sv */
// Top level of the pipelined signed integer divider.
// Depends on sid_pkg and sid_div_step.
//
// Usage:
// Requests arrive on the s_axis channel: numerator in the low DATA_WIDTH bits of
// s_axis_tdata, denominator in the next DATA_WIDTH bits. Each request gives one
// response on the m_axis channel: the quotient, truncated toward zero, in
// m_axis_tdata and a divide-by-zero flag in m_axis_tuser (quotient 0 then).
// The most negative value divided by -1 gives the largest positive value.
// Each request passes through the stages in order: one stage takes the operand
// magnitudes, DATA_WIDTH stages each make one quotient bit with one subtract and
// compare, and the output stage applies the sign. One request is taken every
// cycle while the receiver keeps m_axis_tready high.
// The whole pipeline advances together; when the output holds a response the
// receiver has not taken, every stage holds and s_axis_tready drops, so nothing
// is lost or repeated. Reset clears all valid bits; no request is in flight
// afterwards and s_axis_tready is high.
module signed_int_divider_core
	import sid_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // numerator, denominator
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // quotient
	output logic                   m_axis_tuser   // zero_divisor
);

	logic                  ce;
	logic [DATA_WIDTH-1:0] num;
	logic [DATA_WIDTH-1:0] den;
	div_stage_t            mag_next;
	div_stage_t            mag_s1;
	logic                  valid_s1;
	div_stage_t            mag_view;
	div_stage_t            div_s2 [DATA_WIDTH];
	div_stage_t            last_s2;
	logic [DATA_WIDTH-1:0] quot_next;
	logic [DATA_WIDTH-1:0] quot_s3;
	logic                  zdiv_s3;
	logic                  valid_s3;

	// The pipeline moves whenever the output register is free or being emptied.
	assign ce            = ~valid_s3 | m_axis_tready;
	assign s_axis_tready = ce;

	assign num = s_axis_tdata[DATA_WIDTH-1:0];
	assign den = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

	// Stage 1: operand magnitudes, quotient sign and zero-divisor flag.
	always_comb begin
		mag_next.valid = s_axis_tvalid;
		mag_next.neg   = num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
		mag_next.zero  = (den == '0);
		mag_next.dm    = den[DATA_WIDTH-1] ? (~den + 1'b1) : den;
		mag_next.rem   = '0;
		mag_next.nq    = num[DATA_WIDTH-1] ? (~num + 1'b1) : num;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			mag_s1 <= mag_next;
		end
	end

	always_comb begin
		mag_view       = mag_s1;
		mag_view.valid = valid_s1;
	end

	// Stage 2: one restoring division step per register stage.
	for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
		if (g == 0) begin : g_first
			sid_div_step u_step (
				.clk       (clk),
				.arst_n    (arst_n),
				.ce        (ce),
				.stage_in  (mag_view),
				.stage_out (div_s2[g])
			);
		end else begin : g_next
			sid_div_step u_step (
				.clk       (clk),
				.arst_n    (arst_n),
				.ce        (ce),
				.stage_in  (div_s2[g-1]),
				.stage_out (div_s2[g])
			);
		end
	end

	assign last_s2 = div_s2[DATA_WIDTH-1];

	// Stage 3: apply the sign, saturate the one overflowing case, force zero on a zero divisor.
	always_comb begin
		if (last_s2.zero) begin
			quot_next = '0;
		end else if (last_s2.neg) begin
			quot_next = ~last_s2.nq + 1'b1;
		end else if (last_s2.nq[DATA_WIDTH-1]) begin
			quot_next = INT_MAX;
		end else begin
			quot_next = last_s2.nq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ce) begin
			valid_s3 <= last_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			quot_s3 <= quot_next;
			zdiv_s3 <= last_s2.zero;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = OUT_TDATA_W'(quot_s3);
	assign m_axis_tuser  = zdiv_s3;

endmodule

/* rtl/sid_checker.sv */
// Port-level checks for the signed integer divider, bound to the top level.
// Depends on sid_pkg and signed_int_divider_core.
module sid_checker
	import sid_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	// A stalled response holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled response changed");

	// A divide-by-zero response carries a zero quotient.
	a_zero_quot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("zero divisor gave nonzero quotient");

	// The input side is held back only by a waiting response.
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	// With the output stalled, the request offered is not taken.
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("request taken while output stalled");

endmodule

bind signed_int_divider_core sid_checker u_sid_checker (.*);
